FILE: sv/dia_pkg.sv
// Shared types, constants and helper functions for the descriptor index allocator.
// No dependencies; compile first.
package dia_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam int unsigned VIEW_W     = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned HEAP_W     = 2;
  localparam int unsigned STRIDE_W   = 13;
  localparam int unsigned HANDLE_W   = 64;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OFF_W      = SLOT_W + STRIDE_W;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Heap kinds
  localparam logic [HEAP_W-1:0] HEAP_RES = 2'd0;
  localparam logic [HEAP_W-1:0] HEAP_SMP = 2'd1;
  localparam logic [HEAP_W-1:0] HEAP_RTV = 2'd2;
  localparam logic [HEAP_W-1:0] HEAP_DSV = 2'd3;

  // View kinds
  localparam logic [VIEW_W-1:0] VIEW_CBV = 3'd0;
  localparam logic [VIEW_W-1:0] VIEW_SRV = 3'd1;
  localparam logic [VIEW_W-1:0] VIEW_UAV = 3'd2;
  localparam logic [VIEW_W-1:0] VIEW_SMP = 3'd3;
  localparam logic [VIEW_W-1:0] VIEW_RTV = 3'd4;
  localparam logic [VIEW_W-1:0] VIEW_DSV = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHADER_VIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE   = 3'd5;

  // Reset values
  localparam logic [HEAP_W-1:0]   HEAP_RESET   = HEAP_RES;
  localparam logic [CNT_W-1:0]    EFF_RESET    = CNT_W'(MAX_SLOTS);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic              op;
    logic [VIEW_W-1:0] view_kind;
    logic [SLOT_W-1:0] slot_in;
  } req_t;

  // Stack stage to handle stage
  typedef struct packed {
    logic              valid;
    logic              grant;    // successful allocate
    status_e           status;
    logic [VIEW_W-1:0] view_kind;
    logic [SLOT_W-1:0] pos;      // stack position popped
    logic              use_mem;  // entry rewritten since the last refill
  } stage_t;

  function automatic logic kind_suits(input logic [HEAP_W-1:0] heap,
                                      input logic [VIEW_W-1:0] view);
    logic ok;
    ok = 1'b0;
    case (heap)
      HEAP_RES: ok = (view == VIEW_CBV) || (view == VIEW_SRV) || (view == VIEW_UAV);
      HEAP_SMP: ok = (view == VIEW_SMP);
      HEAP_RTV: ok = (view == VIEW_RTV);
      default:  ok = (view == VIEW_DSV);
    endcase
    return ok;
  endfunction

endpackage

FILE: sv/dia_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on dia_pkg for field widths.
interface dia_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [dia_pkg::VIEW_W-1:0]   view_kind;
  logic [dia_pkg::SLOT_W-1:0]   slot_in;

  modport source (output valid, output op, output view_kind, output slot_in, input ready);
  modport sink   (input valid, input op, input view_kind, input slot_in, output ready);
endinterface

interface dia_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [dia_pkg::STATUS_W-1:0] status;
  logic [dia_pkg::VIEW_W-1:0]   view_kind_out;
  logic [dia_pkg::SLOT_W-1:0]   slot_out;
  logic [dia_pkg::HANDLE_W-1:0] cpu_handle;
  logic [dia_pkg::HANDLE_W-1:0] gpu_handle;

  modport source (output valid, output status, output view_kind_out, output slot_out,
                  output cpu_handle, output gpu_handle, input ready);
  modport sink   (input valid, input status, input view_kind_out, input slot_out,
                  input cpu_handle, input gpu_handle, output ready);
endinterface

FILE: sv/dia_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module dia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/dia_stack.sv
// Free index stack: request checks, stack pointer, fill mark and stack RAM.
// Depends on dia_pkg and dia_ram.
module dia_stack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        acc_i,
  input  dia_pkg::req_t               req_i,
  input  logic [dia_pkg::HEAP_W-1:0]  heap_kind_i,
  input  logic                        refill_i,
  input  logic [dia_pkg::CNT_W-1:0]   refill_cnt_i,
  output dia_pkg::stage_t             stg_o,
  output logic [dia_pkg::SLOT_W-1:0]  rdata_o
);

  logic [dia_pkg::CNT_W-1:0] eff_q, eff_d;
  logic [dia_pkg::CNT_W-1:0] fc_q, fc_d;
  // Lowest stack pointer since the last refill; entries at or above it were rewritten
  logic [dia_pkg::CNT_W-1:0] low_q, low_d;
  logic [dia_pkg::CNT_W-1:0] fc_m1;
  dia_pkg::stage_t           stg_q, stg_d;
  dia_pkg::status_e          status;
  logic                      suits;
  logic                      pop;
  logic                      push;

  assign fc_m1 = fc_q - 1'b1;
  assign suits = dia_pkg::kind_suits(heap_kind_i, req_i.view_kind);

  always_comb begin
    status = dia_pkg::ST_OK;
    if (!suits) begin
      status = dia_pkg::ST_MISMATCH;
    end else if (req_i.op == dia_pkg::OP_ALLOC) begin
      if (fc_q == '0) begin
        status = dia_pkg::ST_EMPTY;
      end
    end else begin
      if (dia_pkg::CNT_W'(req_i.slot_in) >= eff_q) begin
        status = dia_pkg::ST_RANGE;
      end else if (fc_q >= eff_q) begin
        status = dia_pkg::ST_OVERFLOW;
      end
    end
  end

  assign pop  = acc_i && (status == dia_pkg::ST_OK) && (req_i.op == dia_pkg::OP_ALLOC);
  assign push = acc_i && (status == dia_pkg::ST_OK) && (req_i.op == dia_pkg::OP_FREE);

  always_comb begin
    eff_d = eff_q;
    fc_d  = fc_q;
    low_d = low_q;
    if (refill_i) begin
      eff_d = refill_cnt_i;
      fc_d  = refill_cnt_i;
      low_d = refill_cnt_i;
    end else if (pop) begin
      fc_d = fc_m1;
      if (fc_m1 < low_q) begin
        low_d = fc_m1;
      end
    end else if (push) begin
      fc_d = fc_q + 1'b1;
    end
  end

  always_comb begin
    stg_d           = stg_q;
    stg_d.valid     = acc_i;
    stg_d.grant     = pop;
    stg_d.status    = status;
    stg_d.view_kind = req_i.view_kind;
    stg_d.pos       = fc_m1[dia_pkg::SLOT_W-1:0];
    stg_d.use_mem   = (low_q < fc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q <= dia_pkg::EFF_RESET;
      fc_q  <= dia_pkg::EFF_RESET;
      low_q <= dia_pkg::EFF_RESET;
      stg_q <= '0;
    end else begin
      eff_q <= eff_d;
      fc_q  <= fc_d;
      low_q <= low_d;
      if (adv_i) begin
        stg_q <= stg_d;
      end
    end
  end

  dia_ram #(
    .WIDTH (dia_pkg::SLOT_W),
    .DEPTH (dia_pkg::MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (fc_q[dia_pkg::SLOT_W-1:0]),
    .wdata_i (req_i.slot_in),
    .re_i    (pop),
    .raddr_i (fc_m1[dia_pkg::SLOT_W-1:0]),
    .rdata_o (rdata_o)
  );

  assign stg_o = stg_q;

  a_fc_le_eff: assert property (@(posedge clk_i) disable iff (!rst_ni) fc_q <= eff_q)
    else $error("free count above slot count");
  a_low_le_fc: assert property (@(posedge clk_i) disable iff (!rst_ni) low_q <= fc_q)
    else $error("fill mark above free count");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !refill_i |=> fc_q == $past(fc_q) - 1'b1)
    else $error("pop did not lower free count");
  a_push_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !refill_i |=> fc_q == $past(fc_q) + 1'b1)
    else $error("push did not raise free count");

endmodule

FILE: sv/dia_handle.sv
// Handle stage: resolves the popped index and forms cpu and gpu handles into
// the result register. Depends on dia_pkg.
module dia_handle (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  dia_pkg::stage_t               stg_i,
  input  logic [dia_pkg::SLOT_W-1:0]    rdata_i,
  input  logic                          shader_visible_i,
  input  logic [dia_pkg::STRIDE_W-1:0]  stride_i,
  input  logic [dia_pkg::HANDLE_W-1:0]  cpu_base_i,
  input  logic [dia_pkg::HANDLE_W-1:0]  gpu_base_i,
  output logic                          valid_o,
  output logic [dia_pkg::STATUS_W-1:0]  status_o,
  output logic [dia_pkg::VIEW_W-1:0]    view_kind_o,
  output logic [dia_pkg::SLOT_W-1:0]    slot_o,
  output logic [dia_pkg::HANDLE_W-1:0]  cpu_handle_o,
  output logic [dia_pkg::HANDLE_W-1:0]  gpu_handle_o
);

  logic                         valid_q;
  logic [dia_pkg::STATUS_W-1:0] status_q;
  logic [dia_pkg::VIEW_W-1:0]   view_q;
  logic [dia_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [dia_pkg::HANDLE_W-1:0] cpu_q, cpu_d;
  logic [dia_pkg::HANDLE_W-1:0] gpu_q, gpu_d;
  logic [dia_pkg::SLOT_W-1:0]   idx;
  logic [dia_pkg::OFF_W-1:0]    off;

  // Untouched entries still hold their own position
  assign idx = stg_i.use_mem ? rdata_i : stg_i.pos;
  assign off = dia_pkg::OFF_W'(idx) * dia_pkg::OFF_W'(stride_i);

  always_comb begin
    slot_d = '0;
    cpu_d  = '0;
    gpu_d  = '0;
    if (stg_i.grant) begin
      slot_d = idx;
      cpu_d  = cpu_base_i + dia_pkg::HANDLE_W'(off);
      gpu_d  = shader_visible_i ? gpu_base_i + dia_pkg::HANDLE_W'(off) : '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      status_q <= stg_i.status;
      view_q   <= stg_i.grant ? stg_i.view_kind : '0;
      slot_q   <= slot_d;
      cpu_q    <= cpu_d;
      gpu_q    <= gpu_d;
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign view_kind_o  = view_q;
  assign slot_o       = slot_q;
  assign cpu_handle_o = cpu_q;
  assign gpu_handle_o = gpu_q;

endmodule

FILE: sv/descriptor_index_allocator.sv
// Descriptor index allocator: LIFO free-slot stack with cpu/gpu handle generation.
// Pipeline: stack stage register and stack RAM read, then handle multiply-add into the
// result register. Throughput: one request per cycle unless the result is stalled.
// Reset: stack holds 0..1023 via a fill mark, so no clearing pass; requests are
// taken from the first cycle after reset. A slot_count write refills at once.
// Depends on dia_pkg, dia_if, dia_ram, dia_stack and dia_handle.
module descriptor_index_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dia_req_if.sink                         req_i,
  dia_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [dia_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dia_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [dia_pkg::HEAP_W-1:0]   heap_kind_q;
  logic                         shader_vis_q;
  logic [dia_pkg::STRIDE_W-1:0] stride_q;
  logic [dia_pkg::HANDLE_W-1:0] cpu_base_q;
  logic [dia_pkg::HANDLE_W-1:0] gpu_base_q;
  logic                         refill;
  logic [dia_pkg::COUNT_W-1:0]  count_wr;
  logic [dia_pkg::CNT_W-1:0]    refill_cnt;
  logic                         adv;
  logic                         acc;
  dia_pkg::req_t                req;
  dia_pkg::stage_t              stg;
  logic [dia_pkg::SLOT_W-1:0]   rdata;

  assign refill   = cfg_we_i && (cfg_idx_i == dia_pkg::REG_SLOT_COUNT);
  assign count_wr = cfg_wdata_i[dia_pkg::COUNT_W-1:0];
  // Saturate the slot count to the stack depth
  assign refill_cnt = (count_wr > dia_pkg::COUNT_W'(dia_pkg::MAX_SLOTS))
                    ? dia_pkg::CNT_W'(dia_pkg::MAX_SLOTS)
                    : dia_pkg::CNT_W'(count_wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_kind_q  <= dia_pkg::HEAP_RESET;
      shader_vis_q <= 1'b0;
      stride_q     <= dia_pkg::STRIDE_RESET;
      cpu_base_q   <= '0;
      gpu_base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dia_pkg::REG_HEAP_KIND:  heap_kind_q  <= cfg_wdata_i[dia_pkg::HEAP_W-1:0];
        dia_pkg::REG_SHADER_VIS: shader_vis_q <= cfg_wdata_i[0];
        dia_pkg::REG_STRIDE:     stride_q     <= cfg_wdata_i[dia_pkg::STRIDE_W-1:0];
        dia_pkg::REG_CPU_BASE:   cpu_base_q   <= cfg_wdata_i;
        dia_pkg::REG_GPU_BASE:   gpu_base_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances when the result register is free or draining
  assign adv         = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = adv;
  assign acc         = req_i.valid && adv;

  assign req.op        = req_i.op;
  assign req.view_kind = req_i.view_kind;
  assign req.slot_in   = req_i.slot_in;

  dia_stack u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .acc_i        (acc),
    .req_i        (req),
    .heap_kind_i  (heap_kind_q),
    .refill_i     (refill),
    .refill_cnt_i (refill_cnt),
    .stg_o        (stg),
    .rdata_o      (rdata)
  );

  dia_handle u_handle (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .stg_i            (stg),
    .rdata_i          (rdata),
    .shader_visible_i (shader_vis_q),
    .stride_i         (stride_q),
    .cpu_base_i       (cpu_base_q),
    .gpu_base_i       (gpu_base_q),
    .valid_o          (rsp_o.valid),
    .status_o         (rsp_o.status),
    .view_kind_o      (rsp_o.view_kind_out),
    .slot_o           (rsp_o.slot_out),
    .cpu_handle_o     (rsp_o.cpu_handle),
    .gpu_handle_o     (rsp_o.gpu_handle)
  );

endmodule
